// ===== design/clp_pkg.sv =====
package clp_pkg;

  // fixed widths of the request and result fields
  localparam int unsigned WIRE_W      = 10;
  localparam int unsigned LAYER_OUT_W = 16;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned WCOUNT_W    = 11;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // defaults of the top-level parameters
  localparam int unsigned MAX_WIRES_DEFAULT  = 1024;
  localparam int unsigned LAYER_BITS_DEFAULT = 16;

  // generation tag kept next to each ready layer in the table
  localparam int unsigned EPOCH_W = 4;

  localparam logic [WCOUNT_W-1:0] WIRE_COUNT_RESET = WCOUNT_W'(16);
  localparam logic                NORMALIZE_RESET  = 1'b1;

  typedef enum logic {
    REG_WIRE_COUNT = 1'b0,
    REG_NORMALIZE  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_PACK  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CALC,
    S_WRITE_B
  } state_e;

  typedef struct packed {
    logic [WCOUNT_W-1:0] wire_count;
    logic                normalize;
  } cfg_t;

endpackage

// ===== design/comparator_layer_packer.sv =====
// Packs a stream of comparators into sorting-network layers as soon as
// possible. A request is taken when start is high and busy is low; its result
// appears on the result ports for one cycle with result_valid_o high and
// cannot be held off. A comparator that is placed goes through these steps
// before the next request is taken (read both ready entries, update the left
// wire, update the right wire), set by the single write port of the ready
// table; its result shows in the first cycle in which busy is low again.
// Dropped or out-of-range comparators and clears are decided in the cycle in
// which they are taken, with the result in the following cycle. After reset
// busy stays high while every entry of the ready table is swept; every
// fifteenth clear starts the same sweep in the cycle in which its result is
// given. Configuration is taken at any time.
module comparator_layer_packer
  import clp_pkg::*;
#(
  parameter int unsigned MAX_WIRES  = MAX_WIRES_DEFAULT,
  parameter int unsigned LAYER_BITS = LAYER_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic                   opcode_i,
  input  logic [WIRE_W-1:0]      left_wire_i,
  input  logic [WIRE_W-1:0]      right_wire_i,
  output logic                   result_valid_o,
  output logic [LAYER_OUT_W-1:0] assigned_layer_o,
  output logic [WIRE_W-1:0]      out_left_o,
  output logic [WIRE_W-1:0]      out_right_o,
  output logic [LAYER_OUT_W-1:0] network_depth_o,
  output logic [COUNT_W-1:0]     comparator_total_o,
  output logic [1:0]             status_o
);

  localparam int unsigned AW      = $clog2(MAX_WIRES);
  localparam int unsigned ENTRY_W = EPOCH_W + LAYER_BITS;

  cfg_t               cfg;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
  logic [ENTRY_W-1:0] rd_data_a, rd_data_b, wr_data;

  clp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clp_ready_mem #(
    .DEPTH  (MAX_WIRES),
    .DATA_W (ENTRY_W)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data)
  );

  clp_seq #(
    .MAX_WIRES  (MAX_WIRES),
    .LAYER_BITS (LAYER_BITS)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .start_i            (start),
    .busy_o             (busy),
    .opcode_i           (opcode_i),
    .left_wire_i        (left_wire_i),
    .right_wire_i       (right_wire_i),
    .result_valid_o     (result_valid_o),
    .assigned_layer_o   (assigned_layer_o),
    .out_left_o         (out_left_o),
    .out_right_o        (out_right_o),
    .network_depth_o    (network_depth_o),
    .comparator_total_o (comparator_total_o),
    .status_o           (status_o),
    .rd_en_o            (rd_en),
    .rd_addr_a_o        (rd_addr_a),
    .rd_addr_b_o        (rd_addr_b),
    .rd_data_a_i        (rd_data_a),
    .rd_data_b_i        (rd_data_b),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data)
  );

endmodule

// ===== design/clp_cfg.sv =====
module clp_cfg
  import clp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_WIRE_COUNT: cfg_d.wire_count = pwdata[WCOUNT_W-1:0];
        REG_NORMALIZE:  cfg_d.normalize  = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIRE_COUNT: prdata = PDATA_W'(cfg_q.wire_count);
      REG_NORMALIZE:  prdata = PDATA_W'(cfg_q.normalize);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wire_count <= WIRE_COUNT_RESET;
      cfg_q.normalize  <= NORMALIZE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/clp_ready_mem.sv =====
module clp_ready_mem
  import clp_pkg::*;
#(
  parameter int unsigned DEPTH  = MAX_WIRES_DEFAULT,
  parameter int unsigned DATA_W = LAYER_BITS_DEFAULT + EPOCH_W,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_a_i,
  input  logic [AW-1:0]     rd_addr_b_i,
  output logic [DATA_W-1:0] rd_data_a_o,
  output logic [DATA_W-1:0] rd_data_b_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== design/clp_seq.sv =====
module clp_seq
  import clp_pkg::*;
#(
  parameter int unsigned MAX_WIRES  = MAX_WIRES_DEFAULT,
  parameter int unsigned LAYER_BITS = LAYER_BITS_DEFAULT,
  localparam int unsigned AW        = $clog2(MAX_WIRES),
  localparam int unsigned ENTRY_W   = EPOCH_W + LAYER_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   opcode_i,
  input  logic [WIRE_W-1:0]      left_wire_i,
  input  logic [WIRE_W-1:0]      right_wire_i,
  output logic                   result_valid_o,
  output logic [LAYER_OUT_W-1:0] assigned_layer_o,
  output logic [WIRE_W-1:0]      out_left_o,
  output logic [WIRE_W-1:0]      out_right_o,
  output logic [LAYER_OUT_W-1:0] network_depth_o,
  output logic [COUNT_W-1:0]     comparator_total_o,
  output logic [1:0]             status_o,
  // ready table
  output logic                   rd_en_o,
  output logic [AW-1:0]          rd_addr_a_o,
  output logic [AW-1:0]          rd_addr_b_o,
  input  logic [ENTRY_W-1:0]     rd_data_a_i,
  input  logic [ENTRY_W-1:0]     rd_data_b_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [ENTRY_W-1:0]     wr_data_o
);

  localparam logic [LAYER_BITS-1:0] LAYER_MAX = '1;
  localparam logic [EPOCH_W-1:0]    EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0]    EPOCH_ONE = EPOCH_W'(1);
  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;
  localparam logic [AW-1:0]         SWEEP_LAST = AW'(MAX_WIRES - 1);

  state_e                 state_q, state_d;
  logic [WIRE_W-1:0]      a_q, a_d, b_q, b_d;
  logic [EPOCH_W-1:0]     epoch_q, epoch_d;
  logic [AW-1:0]          sweep_q, sweep_d;
  logic [LAYER_BITS-1:0]  depth_q, depth_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [LAYER_BITS-1:0]  layer_q, layer_d;
  logic [LAYER_BITS-1:0]  next_q, next_d;

  logic                   res_valid_q, res_valid_d;
  logic [LAYER_OUT_W-1:0] res_layer_q, res_layer_d;
  logic [WIRE_W-1:0]      res_left_q, res_left_d;
  logic [WIRE_W-1:0]      res_right_q, res_right_d;
  logic [LAYER_OUT_W-1:0] res_depth_q, res_depth_d;
  logic [COUNT_W-1:0]     res_total_q, res_total_d;
  status_e                res_status_q, res_status_d;

  logic [WIRE_W-1:0]      na, nb;
  logic                   swap, range_bad;
  logic [LAYER_BITS-1:0]  ra, rb, layer_max;

  // request decode
  assign swap = cfg_i.normalize && (left_wire_i > right_wire_i);
  assign na   = swap ? right_wire_i : left_wire_i;
  assign nb   = swap ? left_wire_i  : right_wire_i;
  assign range_bad = (32'(na) >= 32'(cfg_i.wire_count)) ||
                     (32'(nb) >= 32'(cfg_i.wire_count)) ||
                     (32'(na) >= 32'(MAX_WIRES)) ||
                     (32'(nb) >= 32'(MAX_WIRES));

  // an entry from an older generation reads as layer zero
  assign ra = (rd_data_a_i[ENTRY_W-1 -: EPOCH_W] == epoch_q) ?
              rd_data_a_i[LAYER_BITS-1:0] : '0;
  assign rb = (rd_data_b_i[ENTRY_W-1 -: EPOCH_W] == epoch_q) ?
              rd_data_b_i[LAYER_BITS-1:0] : '0;
  assign layer_max = (ra > rb) ? ra : rb;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    epoch_d      = epoch_q;
    sweep_d      = sweep_q;
    depth_d      = depth_q;
    count_d      = count_q;
    layer_d      = layer_q;
    next_d       = next_q;
    res_valid_d  = 1'b0;
    res_layer_d  = res_layer_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    res_depth_d  = res_depth_q;
    res_total_d  = res_total_q;
    res_status_d = res_status_q;
    busy_o       = 1'b1;
    rd_en_o      = 1'b0;
    rd_addr_a_o  = AW'(a_q);
    rd_addr_b_o  = AW'(b_q);
    wr_en_o      = 1'b0;
    wr_addr_o    = AW'(a_q);
    wr_data_o    = {epoch_q, next_q};

    case (state_q)
      S_SWEEP: begin
        // tag every entry with generation zero, which is never current
        wr_en_o   = 1'b1;
        wr_addr_o = sweep_q;
        wr_data_o = '0;
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == SWEEP_LAST) begin
          epoch_d = EPOCH_ONE;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          a_d         = na;
          b_d         = nb;
          res_left_d  = na;
          res_right_d = nb;
          res_layer_d = '0;
          res_depth_d = LAYER_OUT_W'(depth_q);
          res_total_d = count_q;
          if (op_e'(opcode_i) == OP_CLEAR) begin
            depth_d      = '0;
            count_d      = '0;
            res_valid_d  = 1'b1;
            res_left_d   = '0;
            res_right_d  = '0;
            res_depth_d  = '0;
            res_total_d  = '0;
            res_status_d = ST_CLEARED;
            if (epoch_q == EPOCH_MAX) begin
              sweep_d = '0;
              state_d = S_SWEEP;
            end else begin
              epoch_d = epoch_q + EPOCH_ONE;
            end
          end else if (range_bad) begin
            res_valid_d  = 1'b1;
            res_status_d = ST_RANGE;
          end else if (na == nb) begin
            res_valid_d  = 1'b1;
            res_status_d = ST_DROPPED;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en_o = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        layer_d   = layer_max;
        next_d    = (layer_max == LAYER_MAX) ? LAYER_MAX : layer_max + LAYER_BITS'(1);
        wr_en_o   = 1'b1;
        wr_addr_o = AW'(a_q);
        wr_data_o = {epoch_q, next_d};
        state_d   = S_WRITE_B;
      end
      S_WRITE_B: begin
        wr_en_o      = 1'b1;
        wr_addr_o    = AW'(b_q);
        wr_data_o    = {epoch_q, next_q};
        depth_d      = (next_q > depth_q) ? next_q : depth_q;
        count_d      = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
        res_valid_d  = 1'b1;
        res_layer_d  = LAYER_OUT_W'(layer_q);
        res_depth_d  = LAYER_OUT_W'(depth_d);
        res_total_d  = count_d;
        res_status_d = ST_PLACED;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      epoch_q     <= '0;
      sweep_q     <= '0;
      depth_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    layer_q      <= layer_d;
    next_q       <= next_d;
    res_layer_q  <= res_layer_d;
    res_left_q   <= res_left_d;
    res_right_q  <= res_right_d;
    res_depth_q  <= res_depth_d;
    res_total_q  <= res_total_d;
    res_status_q <= res_status_d;
  end

  assign result_valid_o     = res_valid_q;
  assign assigned_layer_o   = res_layer_q;
  assign out_left_o         = res_left_q;
  assign out_right_o        = res_right_q;
  assign network_depth_o    = res_depth_q;
  assign comparator_total_o = res_total_q;
  assign status_o           = res_status_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clp_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [LAYER_OUT_W-1:0] LAYER_TOP = '1;
  localparam logic [COUNT_W-1:0] TOTAL_TOP = '1;

  typedef struct {
    logic [LAYER_OUT_W-1:0] layer;
    logic [WIRE_W-1:0]      left;
    logic [WIRE_W-1:0]      right;
    logic [LAYER_OUT_W-1:0] depth;
    logic [COUNT_W-1:0]     total;
    status_e                status;
  } placement_t;

  class layer_tracker;
    logic [WCOUNT_W-1:0]          wire_count = WIRE_COUNT_RESET;
    logic                         normalize = NORMALIZE_RESET;
    logic [LAYER_OUT_W-1:0]       ready_layer [MAX_WIRES_DEFAULT];
    bit   [MAX_WIRES_DEFAULT-1:0] ready_valid;
    logic [LAYER_OUT_W-1:0]       depth_now = '0;
    logic [COUNT_W-1:0]           placed_now = '0;
    placement_t                   expected_placements[$];
    int unsigned                  failures;
    int unsigned                  reg_writes;
    int unsigned                  deepest;
    int unsigned                  status_seen [4];

    function void set_register(reg_idx_e idx, logic [PDATA_W-1:0] value);
      if (idx == REG_WIRE_COUNT) begin
        wire_count = value[WCOUNT_W-1:0];
      end else begin
        normalize = value[0];
      end
      reg_writes++;
    endfunction

    function void note_request(op_e op, logic [WIRE_W-1:0] a, logic [WIRE_W-1:0] b);
      placement_t             p;
      logic [WIRE_W-1:0]      t;
      logic [LAYER_OUT_W-1:0] ra;
      logic [LAYER_OUT_W-1:0] rb;
      logic [LAYER_OUT_W-1:0] nxt;
      p.layer = '0;
      if (op == OP_CLEAR) begin
        ready_valid = '0;
        depth_now = '0;
        placed_now = '0;
        p.left = '0;
        p.right = '0;
        p.status = ST_CLEARED;
      end else begin
        if (normalize && a > b) begin
          t = a;
          a = b;
          b = t;
        end
        p.left = a;
        p.right = b;
        // range is checked ahead of the equal-wire drop
        if ({1'b0, a} >= wire_count || {1'b0, b} >= wire_count) begin
          p.status = ST_RANGE;
        end else if (a == b) begin
          p.status = ST_DROPPED;
        end else begin
          ra = ready_valid[a] ? ready_layer[a] : '0;
          rb = ready_valid[b] ? ready_layer[b] : '0;
          p.layer = (ra > rb) ? ra : rb;
          nxt = (p.layer == LAYER_TOP) ? LAYER_TOP : p.layer + 1'b1;
          ready_layer[a] = nxt;
          ready_layer[b] = nxt;
          ready_valid[a] = 1'b1;
          ready_valid[b] = 1'b1;
          if (nxt > depth_now) depth_now = nxt;
          if (placed_now != TOTAL_TOP) placed_now++;
          p.status = ST_PLACED;
        end
      end
      p.depth = depth_now;
      p.total = placed_now;
      expected_placements.push_back(p);
    endfunction

    function void check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void compare_result(logic [LAYER_OUT_W-1:0] layer, logic [WIRE_W-1:0] left,
                                 logic [WIRE_W-1:0] right, logic [LAYER_OUT_W-1:0] depth,
                                 logic [COUNT_W-1:0] total, logic [1:0] status);
      placement_t want;
      if (expected_placements.size() == 0) begin
        $error("result with no request outstanding: layer %0d wires %0d/%0d status %0d",
               layer, left, right, status);
        failures++;
        return;
      end
      want = expected_placements.pop_front();
      status_seen[want.status]++;
      if (want.status == ST_PLACED && want.layer > deepest) deepest = 32'(want.layer);
      check_field("assigned_layer", COUNT_W'(want.layer), COUNT_W'(layer));
      check_field("out_left", COUNT_W'(want.left), COUNT_W'(left));
      check_field("out_right", COUNT_W'(want.right), COUNT_W'(right));
      check_field("network_depth", COUNT_W'(want.depth), COUNT_W'(depth));
      check_field("comparator_total", want.total, total);
      check_field("status", COUNT_W'(want.status), COUNT_W'(status));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  logic                   start;
  logic                   busy;
  logic                   opcode_i;
  logic [WIRE_W-1:0]      left_wire_i;
  logic [WIRE_W-1:0]      right_wire_i;
  logic                   result_valid_o;
  logic [LAYER_OUT_W-1:0] assigned_layer_o;
  logic [WIRE_W-1:0]      out_left_o;
  logic [WIRE_W-1:0]      out_right_o;
  logic [LAYER_OUT_W-1:0] network_depth_o;
  logic [COUNT_W-1:0]     comparator_total_o;
  logic [1:0]             status_o;

  layer_tracker tracker = new();

  int unsigned       quiet_cycles = 0;
  int unsigned       burst_left = 0;
  logic [WIRE_W-1:0] last_wire = '0;

  always #4 clk_i = ~clk_i;

  comparator_layer_packer dut (.*);

  // results are checked ahead of new requests so a fresh request never meets its own result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        tracker.compare_result(assigned_layer_o, out_left_o, out_right_o, network_depth_o,
                               comparator_total_o, status_o);
      end
      if (start && !busy) begin
        tracker.note_request(op_e'(opcode_i), left_wire_i, right_wire_i);
      end
      if (result_valid_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(op_e op, logic [WIRE_W-1:0] a, logic [WIRE_W-1:0] b);
    start <= 1'b1;
    opcode_i <= op;
    left_wire_i <= a;
    right_wire_i <= b;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_placements.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  task automatic random_request(int unsigned wc);
    int unsigned       pick;
    int unsigned       span;
    logic [WIRE_W-1:0] a;
    logic [WIRE_W-1:0] b;
    pick = $urandom_range(0, 99);
    span = (wc > MAX_WIRES_DEFAULT) ? MAX_WIRES_DEFAULT : wc;
    a = WIRE_W'($urandom);
    b = WIRE_W'($urandom);
    if (pick < 3) begin
      send_request(OP_CLEAR, a, b);
    end else if (pick < 9) begin
      if (span > 0) a = WIRE_W'($urandom_range(0, span - 1));
      send_request(OP_PACK, a, a);
    end else if (pick < 15) begin
      // noise across the whole wire field
      send_request(OP_PACK, a, b);
    end else begin
      if (span > 0) begin
        a = WIRE_W'($urandom_range(0, span - 1));
        b = WIRE_W'($urandom_range(0, span - 1));
        // lean on wires just used so back-to-back requests share a wire
        if ($urandom_range(0, 9) < 4 && last_wire < span) a = last_wire;
      end
      if ($urandom_range(0, 1)) send_request(OP_PACK, a, b);
      else send_request(OP_PACK, b, a);
      last_wire = b;
    end
  endtask

  initial begin
    int unsigned wc;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    start <= 1'b0;
    opcode_i <= OP_PACK;
    left_wire_i <= '0;
    right_wire_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: sixteen wires, smaller wire on the left
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_PACK, 10'd3, 10'd5);
    send_request(OP_PACK, 10'd5, 10'd3);
    send_request(OP_PACK, 10'd0, 10'd15);
    send_request(OP_PACK, 10'd7, 10'd7);
    send_request(OP_PACK, 10'd16, 10'd2);
    send_request(OP_PACK, 10'd1023, 10'd0);
    send_request(OP_PACK, 10'd1023, 10'd1023);
    send_request(OP_PACK, 10'd5, 10'd6);
    send_request(OP_CLEAR, 10'd0, 10'd0);
    send_request(OP_PACK, 10'd5, 10'd3);
    finish_phase();
    write_reg(REG_NORMALIZE, 32'd0);
    write_reg(REG_WIRE_COUNT, 32'd1024);
    send_request(OP_PACK, 10'd1023, 10'd0);
    send_request(OP_PACK, 10'd1023, 10'd1022);
    send_request(OP_PACK, 10'd512, 10'd511);
    send_request(OP_PACK, 10'd1022, 10'd1023);
    send_request(OP_PACK, 10'd1023, 10'd1023);
    finish_phase();
    write_reg(REG_WIRE_COUNT, 32'd0);
    send_request(OP_PACK, 10'd0, 10'd1);
    send_request(OP_PACK, 10'd0, 10'd0);
    finish_phase();
    write_reg(REG_WIRE_COUNT, 32'd1);
    write_reg(REG_NORMALIZE, 32'd1);
    send_request(OP_PACK, 10'd0, 10'd0);
    send_request(OP_PACK, 10'd1, 10'd0);
    finish_phase();
    write_reg(REG_WIRE_COUNT, 32'd2047);
    send_request(OP_PACK, 10'd1023, 10'd0);
    send_request(OP_PACK, 10'd0, 10'd1023);
    finish_phase();
    write_reg(REG_WIRE_COUNT, 32'd2);
    send_request(OP_PACK, 10'd1, 10'd0);
    send_request(OP_PACK, 10'd2, 10'd1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: wc = 16;
        1: wc = 2;
        2: wc = 1024;
        3: wc = $urandom_range(3, 40);
        4: wc = 2047;
        default: wc = $urandom_range(2, 1024);
      endcase
      finish_phase();
      write_reg(REG_WIRE_COUNT, wc);
      write_reg(REG_NORMALIZE, ph % 2);
      repeat (150) random_request(wc);
    end

    finish_phase();
    repeat (8) @(posedge clk_i);

    $display("%0d placed (deepest layer %0d), %0d dropped, %0d out of range, %0d clears",
             tracker.status_seen[ST_PLACED], tracker.deepest, tracker.status_seen[ST_DROPPED],
             tracker.status_seen[ST_RANGE], tracker.status_seen[ST_CLEARED]);
    $display("%0d register writes, wire counts 0 to 2047, both wire orders",
             tracker.reg_writes);
    if (tracker.failures == 0 && tracker.expected_placements.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/clp_pkg.sv
design/clp_cfg.sv
design/clp_ready_mem.sv
design/clp_seq.sv
design/comparator_layer_packer.sv
bench/testbench.sv
